FILE: rtl/order_statistic_set_defines.svh
// Assertion macros used by the order statistic set datapath.
`ifndef ORDER_STATISTIC_SET_DEFINES_SVH
`define ORDER_STATISTIC_SET_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low
`define OSS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("%m: implication check failed");

// Next-cycle implication, sampled on clk, idle while arst_n is low
`define OSS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("%m: next-cycle check failed");

`endif

FILE: rtl/oss_pkg.sv
// Types, constants and controller/datapath structs for the order statistic set.
`timescale 1ns / 1ps
`default_nettype none

package oss_pkg;

	localparam int unsigned KEY_BITS  = 10;
	localparam int unsigned CNT_BITS  = KEY_BITS + 1;
	localparam int unsigned WORD_BITS = CNT_BITS + 1;
	localparam int unsigned UNIVERSE  = 1 << KEY_BITS;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [CNT_BITS-1:0] cnt_t;
	typedef logic [CNT_BITS:0]   wide_t;
	typedef logic [1:0]          req_code_t;

	localparam req_code_t REQ_INSERT = 2'd0;
	localparam req_code_t REQ_DELETE = 2'd1;
	localparam req_code_t REQ_KTH    = 2'd2;
	localparam req_code_t REQ_COUNT  = 2'd3;

	localparam cnt_t  UNIV_CNT  = cnt_t'(UNIVERSE);
	localparam wide_t UNIV_WIDE = wide_t'(UNIVERSE);

	// One tree word: presence of key a, count of tree position a + 1
	typedef struct packed {
		logic present;
		cnt_t count;
	} word_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic clr_wr;
		logic upd_step;
		logic pre_step;
		logic kth_step;
		logic emit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		req_code_t in_type;
		logic      in_bad;
		logic      noop;
		logic      clr_last;
		logic      upd_last;
		logic      pre_last;
		logic      kth_last;
		logic      out_free;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/oss_channels.sv
// Request and result channel interfaces of the order statistic set.
`timescale 1ns / 1ps
`default_nettype none

interface oss_req_if;
	logic                valid;
	logic                ready;
	oss_pkg::req_code_t  req_type;
	oss_pkg::key_t       key;
	oss_pkg::cnt_t       rank;

	modport source (output valid, output req_type, output key, output rank, input ready);
	modport sink   (input valid, input req_type, input key, input rank, output ready);
endinterface

interface oss_res_if;
	logic          valid;
	logic          ready;
	oss_pkg::cnt_t value;
	logic          invalid;

	modport source (output valid, output value, output invalid, input ready);
	modport sink   (input valid, input value, input invalid, output ready);
endinterface

`default_nettype wire

FILE: rtl/oss_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
`default_nettype none

module oss_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: rtl/oss_ctrl.sv
// Sequencing state machine: clearing pass, tree walks and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module oss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  oss_pkg::status_t  st,
	output oss_pkg::cmd_t     cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_UPD   = 3'd3;
	localparam logic [2:0] S_PRE   = 3'd4;
	localparam logic [2:0] S_KTH   = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (st.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					unique case (st.in_type) inside
						oss_pkg::REQ_INSERT, oss_pkg::REQ_DELETE: state_d = S_CHK;
						oss_pkg::REQ_COUNT: state_d = S_PRE;
						oss_pkg::REQ_KTH:   state_d = st.in_bad ? S_EMIT : S_KTH;
						default:            state_d = S_IDLE;
					endcase
				end
			end
			S_CHK: begin
				// first word read: presence decides whether the tree moves
				if (st.noop) begin
					state_d = S_IDLE;
				end else begin
					cmd.upd_step = 1'b1;
					state_d      = st.upd_last ? S_IDLE : S_UPD;
				end
			end
			S_UPD: begin
				cmd.upd_step = 1'b1;
				if (st.upd_last) begin
					state_d = S_IDLE;
				end
			end
			S_PRE: begin
				cmd.pre_step = 1'b1;
				if (st.pre_last) begin
					state_d = S_EMIT;
				end
			end
			S_KTH: begin
				cmd.kth_step = 1'b1;
				if (st.kth_last) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register, clearing pass first after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/oss_datapath.sv
// Tree memory, walk registers, set size and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "order_statistic_set_defines.svh"

module oss_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  oss_pkg::cmd_t      cmd,
	output oss_pkg::status_t   st,
	input  oss_pkg::req_code_t in_req_type,
	input  oss_pkg::key_t      in_key,
	input  oss_pkg::cnt_t      in_rank,
	input  logic               out_ready,
	output logic               out_valid,
	output oss_pkg::cnt_t      out_value,
	output logic               out_invalid
);

	// transaction registers
	oss_pkg::req_code_t req_q;
	oss_pkg::key_t      key_q;
	oss_pkg::cnt_t      pos_q;
	oss_pkg::cnt_t      step_q;
	oss_pkg::cnt_t      rem_q;
	oss_pkg::cnt_t      acc_q;
	logic               inv_q;
	// control state
	oss_pkg::cnt_t      size_q;
	oss_pkg::key_t      clr_q;
	logic               out_vld_q;
	// result payload
	oss_pkg::cnt_t      value_q;
	logic               invalid_q;

	// memory ports
	logic               ram_we;
	oss_pkg::key_t      ram_waddr;
	oss_pkg::word_t     ram_wdata;
	oss_pkg::key_t      ram_raddr;
	oss_pkg::word_t     rd_word;

	logic               is_ins;
	logic               in_bad;
	oss_pkg::cnt_t      upd_low;
	oss_pkg::wide_t     upd_next;
	oss_pkg::key_t      upd_addr;
	logic               upd_first;
	oss_pkg::cnt_t      pre_next;
	oss_pkg::cnt_t      pre_add;
	oss_pkg::wide_t     kth_next;
	logic               kth_take;
	oss_pkg::cnt_t      kth_pos;
	oss_pkg::cnt_t      kth_half;
	oss_pkg::cnt_t      load_pos;

	oss_ram #(
		.WIDTH (oss_pkg::WORD_BITS),
		.DEPTH (oss_pkg::UNIVERSE)
	) u_tree (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (rd_word)
	);

	assign is_ins = (req_q == oss_pkg::REQ_INSERT);
	assign in_bad = (in_rank == '0) || (in_rank > size_q);

	// update walk: pos += lowest set bit
	assign upd_low   = pos_q & (~pos_q + 1'b1);
	assign upd_next  = {1'b0, pos_q} + {1'b0, upd_low};
	assign upd_addr  = oss_pkg::key_t'(pos_q - 1'b1);
	assign upd_first = (upd_addr == key_q);

	// prefix walk: drop lowest set bit, tree position zero adds nothing
	assign pre_next = pos_q & (pos_q - 1'b1);
	assign pre_add  = (pos_q != '0) ? rd_word.count : '0;

	// descent: take the half-step if it stays inside the tree and its count is below the remaining rank
	assign kth_next = {1'b0, pos_q} + {1'b0, step_q};
	assign kth_take = (kth_next <= oss_pkg::UNIV_WIDE) && (rd_word.count < rem_q);
	assign kth_pos  = kth_take ? kth_next[oss_pkg::CNT_BITS-1:0] : pos_q;
	assign kth_half = step_q >> 1;

	// start position per request
	always_comb begin
		unique case (in_req_type) inside
			oss_pkg::REQ_INSERT, oss_pkg::REQ_DELETE: load_pos = oss_pkg::cnt_t'(in_key) + 1'b1;
			oss_pkg::REQ_COUNT: load_pos = oss_pkg::cnt_t'(in_key);
			default:            load_pos = '0;
		endcase
	end

	// read address: tree position p sits at word p - 1
	always_comb begin
		ram_raddr = '0;
		if (cmd.load) begin
			unique case (in_req_type) inside
				oss_pkg::REQ_INSERT, oss_pkg::REQ_DELETE: ram_raddr = in_key;
				oss_pkg::REQ_COUNT: ram_raddr = in_key - 1'b1;
				default:            ram_raddr = '1;
			endcase
		end else if (cmd.upd_step) begin
			ram_raddr = oss_pkg::key_t'(upd_next - 1'b1);
		end else if (cmd.pre_step) begin
			ram_raddr = oss_pkg::key_t'(pre_next - 1'b1);
		end else if (cmd.kth_step) begin
			ram_raddr = oss_pkg::key_t'(kth_pos + kth_half - 1'b1);
		end
	end

	// write port: clearing pass or read-modify-write of the update walk
	always_comb begin
		ram_we    = cmd.clr_wr | cmd.upd_step;
		ram_waddr = cmd.clr_wr ? clr_q : upd_addr;
		ram_wdata = '0;
		if (!cmd.clr_wr) begin
			ram_wdata.present = upd_first ? is_ins : rd_word.present;
			ram_wdata.count   = is_ins ? rd_word.count + 1'b1 : rd_word.count - 1'b1;
		end
	end

	// set size, clear sweep and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= '0;
			clr_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.upd_step && upd_first) begin
				size_q <= is_ins ? size_q + 1'b1 : size_q - 1'b1;
			end
			if (cmd.emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// walk registers and result payload
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= in_req_type;
			key_q  <= in_key;
			pos_q  <= load_pos;
			step_q <= oss_pkg::UNIV_CNT;
			rem_q  <= in_rank;
			acc_q  <= '0;
			inv_q  <= (in_req_type == oss_pkg::REQ_KTH) && in_bad;
		end
		if (cmd.upd_step) begin
			pos_q <= upd_next[oss_pkg::CNT_BITS-1:0];
		end
		if (cmd.pre_step) begin
			pos_q <= pre_next;
			acc_q <= acc_q + pre_add;
		end
		if (cmd.kth_step) begin
			pos_q  <= kth_pos;
			rem_q  <= kth_take ? rem_q - rd_word.count : rem_q;
			step_q <= kth_half;
			acc_q  <= kth_pos;
		end
		if (cmd.emit) begin
			value_q   <= inv_q ? '0 : acc_q;
			invalid_q <= inv_q;
		end
	end

	assign out_valid   = out_vld_q;
	assign out_value   = value_q;
	assign out_invalid = invalid_q;

	// status back to the controller
	always_comb begin
		st          = '0;
		st.in_type  = in_req_type;
		st.in_bad   = in_bad;
		st.noop     = is_ins ? rd_word.present : !rd_word.present;
		st.clr_last = &clr_q;
		st.upd_last = (upd_next > oss_pkg::UNIV_WIDE);
		st.pre_last = (pre_next == '0);
		st.kth_last = step_q[0];
		st.out_free = !out_vld_q || out_ready;
	end

	// checks
	`OSS_ASSERT_IMPL(a_emit_when_free, cmd.emit, st.out_free)
	`OSS_ASSERT_IMPL(a_one_command, 1'b1, $onehot0(cmd))
	`OSS_ASSERT_NEXT(a_size_moves, cmd.upd_step && upd_first, size_q != $past(size_q))
	`OSS_ASSERT_IMPL(a_result_range, cmd.emit && !inv_q, acc_q < oss_pkg::UNIV_CNT)

endmodule

`default_nettype wire

FILE: rtl/order_statistic_set.sv
// Top level of the order statistic set: Fenwick tree of key counts.
//
//   channel  dir  payload                  transaction
//   req      in   req_type, key, rank      valid & ready
//   res      out  value, invalid           valid & ready
//
// Insert or delete ends after the first word read if it is a no-op, otherwise it walks
// one tree level per cycle, through the single read and write port of the tree RAM.
// Count walks the prefix path, kth descends the tree, kth with bad rank goes to the result.
// After reset the tree RAM is cleared, one word a cycle, all 1024 words, with ready low.
// The result register is separate, so a new request is taken while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module order_statistic_set (
	input  logic       clk,
	input  logic       arst_n,
	oss_req_if.sink    req,
	oss_res_if.source  res
);

	oss_pkg::cmd_t    cmd;
	oss_pkg::status_t st;

	// sequencing
	oss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// tree storage and arithmetic
	oss_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.in_req_type (req.req_type),
		.in_key      (req.key),
		.in_rank     (req.rank),
		.out_ready   (res.ready),
		.out_valid   (res.valid),
		.out_value   (res.value),
		.out_invalid (res.invalid)
	);

endmodule

`default_nettype wire
